@@ design/drm_pkg.sv @@
`default_nettype none
package drm_pkg;

  // rectangle edges in canvas coordinates: y2 is y + h - 1, x2 is x + w - 1 aligned and clamped
  localparam int COORD_W  = 14;
  localparam int AREA_W   = 2 * COORD_W;
  localparam int SCR_W    = 16;
  localparam int CW_W     = 13;
  localparam int RX_W     = 12;
  localparam int RW_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_SLOTS = 4;

  localparam logic [CW_W-1:0] CANVAS_W_RST = CW_W'(320);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_EN = 2'd3;

  // item opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // multiplier operand select
  localparam logic MUL_JOIN = 1'b0;
  localparam logic MUL_SLOT = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
  } rect_t;

  typedef struct packed {
    logic mul_en;
    logic mul_sel;
  } ru_ctl_t;

  typedef struct packed {
    logic  overlap;
    rect_t merged;
  } ru_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COST_J,
    ST_COST_S,
    ST_COST_C,
    ST_MERGE,
    ST_FLUSH,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

@@ design/drm_slot_store.sv @@
`default_nettype none
module drm_slot_store #(
  parameter int SLOTS = drm_pkg::DEF_SLOTS,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [IDX_W-1:0]     waddr,
  input  wire drm_pkg::rect_t       wdata,
  input  wire logic [IDX_W-1:0]     raddr,
  output drm_pkg::rect_t            rdata
);

  // contents undefined until written; only entries below the fill count are read
  drm_pkg::rect_t slot_r [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      slot_r[waddr] <= wdata;
    end
  end

  assign rdata = slot_r[raddr];

endmodule
`default_nettype wire

@@ design/drm_region_unit.sv @@
`default_nettype none
module drm_region_unit (
  input  wire logic                         clk,
  input  wire drm_pkg::rect_t               slot_i,
  input  wire drm_pkg::rect_t               new_i,
  input  wire drm_pkg::ru_ctl_t             ctl_i,
  output drm_pkg::ru_stat_t                 stat_o,
  output logic [drm_pkg::AREA_W-1:0]        prod_o
);

  drm_pkg::rect_t               join_c;
  logic [drm_pkg::COORD_W-1:0]  mul_a;
  logic [drm_pkg::COORD_W-1:0]  mul_b;
  logic [drm_pkg::AREA_W-1:0]   prod_r;
  logic [drm_pkg::AREA_W-1:0]   prod_nxt;

  always_comb begin
    join_c.x1 = (slot_i.x1 < new_i.x1) ? slot_i.x1 : new_i.x1;
    join_c.y1 = (slot_i.y1 < new_i.y1) ? slot_i.y1 : new_i.y1;
    join_c.x2 = (slot_i.x2 > new_i.x2) ? slot_i.x2 : new_i.x2;
    join_c.y2 = (slot_i.y2 > new_i.y2) ? slot_i.y2 : new_i.y2;
  end

  assign stat_o.merged  = join_c;
  assign stat_o.overlap = !((slot_i.x2 < new_i.x1) || (new_i.x2 < slot_i.x1) ||
                            (slot_i.y2 < new_i.y1) || (new_i.y2 < slot_i.y1));

  // width and height of the selected box, edges are ordered so no borrow
  always_comb begin
    if (ctl_i.mul_sel == drm_pkg::MUL_SLOT) begin
      mul_a = slot_i.x2 - slot_i.x1 + drm_pkg::COORD_W'(1);
      mul_b = slot_i.y2 - slot_i.y1 + drm_pkg::COORD_W'(1);
    end else begin
      mul_a = join_c.x2 - join_c.x1 + drm_pkg::COORD_W'(1);
      mul_b = join_c.y2 - join_c.y1 + drm_pkg::COORD_W'(1);
    end
    prod_nxt = drm_pkg::AREA_W'(mul_a) * drm_pkg::AREA_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (ctl_i.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_o = prod_r;

endmodule
`default_nettype wire

@@ design/dirty_region_merger_unit.sv @@
// add, batching on: a scan merges the item into the first overlapping slot or fills a
//   free one; with the store full the shared area multiplier picks the cheapest slot
// add, batching off: one beat out; flush: one beat per stored slot; both wait on stall
// one item at a time; the output register lets the next item in while a beat waits
// reset (rst_n low, synchronous): idle, store empty, registers to their reset values;
//   slot contents are not cleared
`default_nettype none
module dirty_region_merger_unit #(
  parameter int SLOTS = drm_pkg::DEF_SLOTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // item channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_op,
  input  wire logic [drm_pkg::RX_W-1:0]          in_rect_x,
  input  wire logic [drm_pkg::RX_W-1:0]          in_rect_y,
  input  wire logic [drm_pkg::RW_W-1:0]          in_rect_w,
  input  wire logic [drm_pkg::RW_W-1:0]          in_rect_h,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [drm_pkg::SCR_W-1:0]       out_left,
  output logic signed [drm_pkg::SCR_W-1:0]       out_top,
  output logic signed [drm_pkg::SCR_W-1:0]       out_right,
  output logic signed [drm_pkg::SCR_W-1:0]       out_bottom,
  output logic                                   out_last,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [drm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [drm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SLOTS - 1);

  localparam int CW = drm_pkg::COORD_W;

  // configuration registers
  logic [drm_pkg::CW_W-1:0]          canvas_w_r;
  logic signed [drm_pkg::SCR_W-1:0]  origin_x_r;
  logic signed [drm_pkg::SCR_W-1:0]  origin_y_r;
  logic                              batch_en_r;

  drm_pkg::state_t   state_r;
  drm_pkg::state_t   state_nxt;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  idx_r;
  logic [IDX_W-1:0]  best_r;
  logic [drm_pkg::AREA_W-1:0] min_growth_r;
  logic [drm_pkg::AREA_W-1:0] join_area_r;
  drm_pkg::rect_t    new_r;

  logic              out_valid_r;
  drm_pkg::rect_t    out_rect_r;
  logic              out_last_r;

  // accept and output strobes
  logic              in_acc;
  logic              out_free;
  logic              out_load;
  drm_pkg::rect_t    out_src;
  logic              out_last_src;

  // aligned incoming rectangle
  logic [drm_pkg::RW_W-1:0] w_eff;
  logic [drm_pkg::RW_W-1:0] h_eff;
  logic [drm_pkg::CW_W-1:0] max_x;
  logic [CW-1:0]            x2_raw;
  logic [CW-1:0]            x1_al;
  drm_pkg::rect_t           new_c;

  // store and shared unit hookup
  logic                 st_we;
  logic [IDX_W-1:0]     st_waddr;
  drm_pkg::rect_t       st_wdata;
  logic [IDX_W-1:0]     st_raddr;
  drm_pkg::rect_t       slot_rd;
  drm_pkg::ru_ctl_t     ru_ctl;
  drm_pkg::ru_stat_t    ru_stat;
  logic [drm_pkg::AREA_W-1:0] prod;
  logic [drm_pkg::AREA_W-1:0] cost;
  logic                 cost_win;

  logic                 scan_end;
  logic                 flush_end;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != drm_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign scan_end  = (idx_r == count_r);
  assign flush_end = (idx_r + CNT_W'(1) == count_r);

  // --------------------------------------------------------------------------
  // align the incoming rectangle: left down to a multiple of four, right up to
  // three mod four and clamped to the canvas, left never past right
  // --------------------------------------------------------------------------
  always_comb begin
    w_eff  = (in_rect_w == '0) ? drm_pkg::RW_W'(1) : in_rect_w;
    h_eff  = (in_rect_h == '0) ? drm_pkg::RW_W'(1) : in_rect_h;
    max_x  = ((canvas_w_r == '0) ? drm_pkg::CW_W'(1) : canvas_w_r) - drm_pkg::CW_W'(1);
    x2_raw = (CW'(in_rect_x) + CW'(w_eff) - CW'(1)) | CW'(3);
    x1_al  = CW'({in_rect_x[drm_pkg::RX_W-1:2], 2'b00});
    new_c.y1 = CW'(in_rect_y);
    new_c.y2 = CW'(in_rect_y) + CW'(h_eff) - CW'(1);
    new_c.x2 = (x2_raw > CW'(max_x)) ? CW'(max_x) : x2_raw;
    new_c.x1 = (x1_al > new_c.x2) ? new_c.x2 : x1_al;
  end

  // --------------------------------------------------------------------------
  // storage and the shared overlap / join / area unit
  // --------------------------------------------------------------------------
  drm_slot_store #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (slot_rd)
  );

  drm_region_unit u_ru (
    .clk    (clk),
    .slot_i (slot_rd),
    .new_i  (new_r),
    .ctl_i  (ru_ctl),
    .stat_o (ru_stat),
    .prod_o (prod)
  );

  // join area is never below the slot area, so the cost fits the product width
  assign cost     = join_area_r - prod;
  assign cost_win = (idx_r == '0) || (cost < min_growth_r);

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      drm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_op == drm_pkg::OP_FLUSH) begin
            state_nxt = (count_r == '0) ? drm_pkg::ST_IDLE : drm_pkg::ST_FLUSH;
          end else if (!batch_en_r) begin
            state_nxt = drm_pkg::ST_EMIT;
          end else begin
            state_nxt = drm_pkg::ST_SCAN;
          end
        end
      end
      drm_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = (count_r == FULL_CNT) ? drm_pkg::ST_COST_J : drm_pkg::ST_IDLE;
        end else if (ru_stat.overlap) begin
          state_nxt = drm_pkg::ST_IDLE;
        end
      end
      drm_pkg::ST_COST_J: state_nxt = drm_pkg::ST_COST_S;
      drm_pkg::ST_COST_S: state_nxt = drm_pkg::ST_COST_C;
      drm_pkg::ST_COST_C: begin
        state_nxt = (idx_r == LAST_IDX) ? drm_pkg::ST_MERGE : drm_pkg::ST_COST_J;
      end
      drm_pkg::ST_MERGE: state_nxt = drm_pkg::ST_IDLE;
      drm_pkg::ST_FLUSH: begin
        if (out_free && flush_end) begin
          state_nxt = drm_pkg::ST_IDLE;
        end
      end
      drm_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = drm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = drm_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // control outputs
  // --------------------------------------------------------------------------
  always_comb begin
    st_we          = 1'b0;
    st_waddr       = idx_r[IDX_W-1:0];
    st_wdata       = ru_stat.merged;
    st_raddr       = idx_r[IDX_W-1:0];
    ru_ctl.mul_en  = 1'b0;
    ru_ctl.mul_sel = drm_pkg::MUL_JOIN;
    out_load       = 1'b0;
    out_src        = slot_rd;
    out_last_src   = flush_end;
    case (state_r)
      drm_pkg::ST_SCAN: begin
        if (scan_end) begin
          // no overlap: take the next free slot if there is one
          if (count_r != FULL_CNT) begin
            st_we    = 1'b1;
            st_waddr = count_r[IDX_W-1:0];
            st_wdata = new_r;
          end
        end else if (ru_stat.overlap) begin
          st_we = 1'b1;
        end
      end
      drm_pkg::ST_COST_J: begin
        ru_ctl.mul_en  = 1'b1;
        ru_ctl.mul_sel = drm_pkg::MUL_JOIN;
      end
      drm_pkg::ST_COST_S: begin
        ru_ctl.mul_en  = 1'b1;
        ru_ctl.mul_sel = drm_pkg::MUL_SLOT;
      end
      drm_pkg::ST_MERGE: begin
        st_raddr = best_r;
        st_waddr = best_r;
        st_we    = 1'b1;
      end
      drm_pkg::ST_FLUSH: begin
        out_load = out_free;
      end
      drm_pkg::ST_EMIT: begin
        out_load     = out_free;
        out_src      = new_r;
        out_last_src = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= drm_pkg::ST_IDLE;
      count_r    <= '0;
      idx_r      <= '0;
      canvas_w_r <= drm_pkg::CANVAS_W_RST;
      origin_x_r <= '0;
      origin_y_r <= '0;
      batch_en_r <= 1'b1;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          drm_pkg::CFG_CANVAS_W: canvas_w_r <= cfg_data[drm_pkg::CW_W-1:0];
          drm_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_data;
          drm_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_data;
          drm_pkg::CFG_BATCH_EN: batch_en_r <= cfg_data[0];
          default: begin
          end
        endcase
      end

      case (state_r)
        drm_pkg::ST_IDLE: begin
          idx_r <= '0;
        end
        drm_pkg::ST_SCAN: begin
          if (scan_end) begin
            idx_r <= '0;
            if (count_r != FULL_CNT) begin
              count_r <= count_r + CNT_W'(1);
            end
          end else begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        drm_pkg::ST_COST_C: begin
          idx_r <= idx_r + CNT_W'(1);
        end
        drm_pkg::ST_FLUSH: begin
          if (out_free) begin
            idx_r <= idx_r + CNT_W'(1);
            if (flush_end) begin
              count_r <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload of the item and the cost search, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      new_r <= new_c;
    end
    if (state_r == drm_pkg::ST_COST_S) begin
      join_area_r <= prod;
    end
    if ((state_r == drm_pkg::ST_COST_C) && cost_win) begin
      min_growth_r <= cost;
      best_r       <= idx_r[IDX_W-1:0];
    end
  end

  // output register, parts the result channel from the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rect_r <= out_src;
      out_last_r <= out_last_src;
    end
  end

  // shift by the canvas origin, wrapping to the screen word
  assign out_valid  = out_valid_r;
  assign out_left   = {2'b00, out_rect_r.x1} + origin_x_r;
  assign out_top    = {2'b00, out_rect_r.y1} + origin_y_r;
  assign out_right  = {2'b00, out_rect_r.x2} + origin_x_r;
  assign out_bottom = {2'b00, out_rect_r.y2} + origin_y_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire
